// File: src/biquad_frequency_response_defines.svh
// assertion macros for the biquad frequency response block
// no dependencies; used by modules that carry concurrent checks
`ifndef BIQUAD_FREQUENCY_RESPONSE_DEFINES_SVH
`define BIQUAD_FREQUENCY_RESPONSE_DEFINES_SVH
`ifndef SYNTHESIS
`define BFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bfr check failed");
`define BFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfr check failed");
`else
`define BFR_ASSERT(lbl, prop)
`define BFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/bfr_pkg.sv
// types, constants and helpers for the biquad frequency response block
// no dependencies; imported by biquad_frequency_response
package bfr_pkg;

  localparam int PHASE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 28;
  localparam int NUM_STEPS      = 6;
  localparam int SIN_STEPS      = 5;
  localparam int DIV_STEPS      = 32;
  localparam int DRW            = 100;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;

  // register indexes
  localparam logic [2:0] REG_DEN_C0 = 3'd0;
  localparam logic [2:0] REG_DEN_C1 = 3'd1;
  localparam logic [2:0] REG_DEN_C2 = 3'd2;
  localparam logic [2:0] REG_NUM_C0 = 3'd3;
  localparam logic [2:0] REG_NUM_C1 = 3'd4;
  localparam logic [2:0] REG_NUM_C2 = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [29:0] x;
    logic [29:0] x2;
  } ang_t;

  typedef struct packed {
    logic [33:0] hh;
    logic [32:0] hl;
    logic [32:0] lh;
    logic [31:0] ll;
  } pp_t;

  typedef struct packed {
    logic [DRW-1:0] m;
    logic [31:0]    q;
    logic           neg;
    logic           sat;
  } div_t;

  // series divisors of the cosine polynomial
  function automatic logic [7:0] cos_div_k(input int j);
    logic [7:0] k;
    case (j)
      0: k = 8'd132;
      1: k = 8'd90;
      2: k = 8'd56;
      3: k = 8'd30;
      4: k = 8'd12;
      default: k = 8'd2;
    endcase
    return k;
  endfunction

  // series divisors of the sine polynomial
  function automatic logic [7:0] sin_div_k(input int j);
    logic [7:0] k;
    case (j)
      0: k = 8'd110;
      1: k = 8'd72;
      2: k = 8'd42;
      3: k = 8'd20;
      default: k = 8'd6;
    endcase
    return k;
  endfunction

  // magnitude of a rounded sum
  function automatic logic [32:0] mag34(input logic [33:0] v);
    logic [33:0] n;
    n = ~v + 34'd1;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

  // partial products of a 33 by 33 bit magnitude product
  function automatic pp_t pp_calc(input logic [32:0] a, input logic [32:0] b);
    pp_t p;
    p.hh = 34'(a[32:16]) * 34'(b[32:16]);
    p.hl = 33'(a[32:16]) * 33'(b[15:0]);
    p.lh = 33'(a[15:0]) * 33'(b[32:16]);
    p.ll = 32'(a[15:0]) * 32'(b[15:0]);
    return p;
  endfunction

endpackage

// File: src/biquad_frequency_response.sv
// biquad frequency response: deeply pipelined sine/cosine, complex sums and divide
// depends on bfr_pkg and biquad_frequency_response_defines.svh
//
// Usage
//   in_valid/in_ready carry one phase per transaction (fraction of a full turn).
//   out_valid/out_ready carry resp_real, resp_imag (Q7.24) and status
//   (ok, saturated, denominator zero) for each accepted phase, in order.
//   cfg_we/cfg_index/cfg_data write the six Q3.28 coefficients; write them
//   only while no transaction is in flight. Indexes beyond the list are dropped.
// Throughput
//   One transaction per cycle while the output is not stalled: the pipeline is
//   built of register stages, chiefly the 32 one-bit restoring divide stages,
//   six three-stage polynomial steps and the split 33x33 magnitude products.
// Reset
//   rst_n low clears all valid bits and loads a0 = b0 = 1.0, other coefficients 0.
// Stall
//   while out_valid is high and out_ready low the whole pipeline holds and
//   in_ready is low; nothing is lost or repeated.
`include "biquad_frequency_response_defines.svh"
module biquad_frequency_response
  import bfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PHASE_BITS-1:0] in_phase,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_resp_real,
  output logic [31:0]           out_resp_imag,
  output logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int NVLD = 4 + 3 * NUM_STEPS + 7 + DIV_STEPS;

  logic en;
  logic [NVLD-1:0] vld_r;
  logic            out_valid_r;
  logic [31:0]     out_resp_real_r, out_resp_imag_r;
  logic [1:0]      out_status_r;

  logic signed [31:0] den_c0_r, den_c1_r, den_c2_r, num_c0_r, num_c1_r, num_c2_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_resp_real = out_resp_real_r;
  assign out_resp_imag = out_resp_imag_r;
  assign out_status    = out_status_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      den_c0_r <= 32'sd1 <<< COEF_FRAC_BITS;
      den_c1_r <= '0;
      den_c2_r <= '0;
      num_c0_r <= 32'sd1 <<< COEF_FRAC_BITS;
      num_c1_r <= '0;
      num_c2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEN_C0: den_c0_r <= cfg_data;
        REG_DEN_C1: den_c1_r <= cfg_data;
        REG_DEN_C2: den_c2_r <= cfg_data;
        REG_NUM_C0: num_c0_r <= cfg_data;
        REG_NUM_C1: num_c1_r <= cfg_data;
        REG_NUM_C2: num_c2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NVLD-2:0], in_valid};
      out_valid_r <= vld_r[NVLD-1];
    end
  end

  // angle fold: quadrant, reflect into the lower half of the octant pair
  logic [31:0] ang_a [2];
  logic [29:0] ang_r [2];
  logic [1:0]  f_quad_r [2];
  logic        f_swap_r [2];
  logic [29:0] f_rf_r [2];

  assign ang_a[0] = {in_phase, {(32 - PHASE_BITS){1'b0}}};
  assign ang_a[1] = {ang_a[0][30:0], 1'b0};
  assign ang_r[0] = ang_a[0][29:0];
  assign ang_r[1] = ang_a[1][29:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 2; g++) begin
        f_quad_r[g] <= ang_a[g][31:30];
        f_swap_r[g] <= ang_r[g] > 30'h2000_0000;
        f_rf_r[g]   <= (ang_r[g] > 30'h2000_0000) ?
                       30'(ONE_Q30 - {1'b0, ang_r[g]}) : ang_r[g];
      end
    end
  end

  // radians: multiply by pi, then round and square
  ang_t        a2_r [2], a3_r [2], a4_r [2];
  logic [61:0] p_prod_r [2];
  logic [59:0] xx_r [2];
  logic [29:0] x_c [2];

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      x_c[g] = 30'((63'(p_prod_r[g]) + 63'(ONE_Q30)) >> 31);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 2; g++) begin
        a2_r[g]     <= '{quad: f_quad_r[g], swap: f_swap_r[g], x: '0, x2: '0};
        p_prod_r[g] <= 62'(f_rf_r[g]) * 62'(PI_Q30);
        a3_r[g]     <= '{quad: a2_r[g].quad, swap: a2_r[g].swap, x: x_c[g], x2: '0};
        xx_r[g]     <= 60'(x_c[g]) * 60'(x_c[g]);
        a4_r[g]     <= '{quad: a3_r[g].quad, swap: a3_r[g].swap, x: a3_r[g].x,
                         x2: 30'((61'(xx_r[g]) + 61'(ONE_Q30 >> 1)) >> 30)};
      end
    end
  end

  // polynomial steps, three stages each
  ang_t        ch_ang [NUM_STEPS+1][2];
  logic [30:0] ch_tc [NUM_STEPS+1][2];
  logic [30:0] ch_ts [NUM_STEPS+1][2];
  ang_t        sa_ang_r [NUM_STEPS][2];
  ang_t        sb_ang_r [NUM_STEPS][2];
  ang_t        sc_ang_r [NUM_STEPS][2];
  logic [60:0] sa_mc_r [NUM_STEPS][2];
  logic [60:0] sa_ms_r [NUM_STEPS][2];
  logic [30:0] sb_pc_r [NUM_STEPS][2];
  logic [30:0] sb_ps_r [NUM_STEPS][2];
  logic [62:0] sb_qc_r [NUM_STEPS][2];
  logic [62:0] sb_qs_r [NUM_STEPS][2];
  logic [30:0] sc_tc_r [NUM_STEPS][2];
  logic [30:0] sc_ts_r [NUM_STEPS][2];

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      ch_ang[0][g] = a4_r[g];
      ch_tc[0][g]  = ONE_Q30;
      ch_ts[0][g]  = ONE_Q30;
      for (int j = 0; j < NUM_STEPS; j++) begin
        ch_ang[j+1][g] = sc_ang_r[j][g];
        ch_tc[j+1][g]  = sc_tc_r[j][g];
        ch_ts[j+1][g]  = sc_ts_r[j][g];
      end
    end
  end

  for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
    localparam logic [7:0]  KC = cos_div_k(j);
    localparam logic [31:0] MC = 32'(64'h1_0000_0000 / 64'(KC));
    logic [30:0] qc0 [2];
    logic [38:0] remc [2];

    always_comb begin
      for (int g = 0; g < 2; g++) begin
        qc0[g]  = 31'(sb_qc_r[j][g] >> 32);
        remc[g] = 39'(sb_pc_r[j][g]) - 39'(qc0[g]) * 39'(KC);
      end
    end

    // cosine chain: product, reciprocal product, corrected quotient
    always_ff @(posedge clk) begin
      if (en) begin
        for (int g = 0; g < 2; g++) begin
          sa_ang_r[j][g] <= ch_ang[j][g];
          sa_mc_r[j][g]  <= 61'(ch_ang[j][g].x2) * 61'(ch_tc[j][g]);
          sb_ang_r[j][g] <= sa_ang_r[j][g];
          sb_pc_r[j][g]  <= 31'(sa_mc_r[j][g] >> 30);
          sb_qc_r[j][g]  <= 63'(31'(sa_mc_r[j][g] >> 30)) * 63'(MC);
          sc_ang_r[j][g] <= sb_ang_r[j][g];
          sc_tc_r[j][g]  <= ONE_Q30 - (qc0[g] + 31'(remc[g] >= 39'(KC)));
        end
      end
    end

    if (j < SIN_STEPS) begin : g_sin_poly
      localparam logic [7:0]  KS = sin_div_k(j);
      localparam logic [31:0] MS = 32'(64'h1_0000_0000 / 64'(KS));
      logic [30:0] qs0 [2];
      logic [38:0] rems [2];

      always_comb begin
        for (int g = 0; g < 2; g++) begin
          qs0[g]  = 31'(sb_qs_r[j][g] >> 32);
          rems[g] = 39'(sb_ps_r[j][g]) - 39'(qs0[g]) * 39'(KS);
        end
      end

      // sine chain step
      always_ff @(posedge clk) begin
        if (en) begin
          for (int g = 0; g < 2; g++) begin
            sa_ms_r[j][g] <= 61'(ch_ang[j][g].x2) * 61'(ch_ts[j][g]);
            sb_ps_r[j][g] <= 31'(sa_ms_r[j][g] >> 30);
            sb_qs_r[j][g] <= 63'(31'(sa_ms_r[j][g] >> 30)) * 63'(MS);
            sc_ts_r[j][g] <= ONE_Q30 - (qs0[g] + 31'(rems[g] >= 39'(KS)));
          end
        end
      end
    end else begin : g_sin_fin
      // sine = x * t, rounded
      always_ff @(posedge clk) begin
        if (en) begin
          for (int g = 0; g < 2; g++) begin
            sa_ms_r[j][g] <= 61'(ch_ang[j][g].x) * 61'(ch_ts[j][g]);
            sb_ps_r[j][g] <= '0;
            sb_qs_r[j][g] <= 63'(sa_ms_r[j][g]);
            sc_ts_r[j][g] <= 31'((64'(sb_qs_r[j][g]) + 64'(ONE_Q30 >> 1)) >> 30);
          end
        end
      end
    end
  end

  // quadrant mapping to signed cosine and sine
  logic signed [31:0] cs_c_r [2], cs_s_r [2];
  logic [31:0]        cc_c [2], ss_c [2];

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      cc_c[g] = ch_ang[NUM_STEPS][g].swap ? 32'(ch_ts[NUM_STEPS][g]) :
                                           32'(ch_tc[NUM_STEPS][g]);
      ss_c[g] = ch_ang[NUM_STEPS][g].swap ? 32'(ch_tc[NUM_STEPS][g]) :
                                           32'(ch_ts[NUM_STEPS][g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 2; g++) begin
        case (ch_ang[NUM_STEPS][g].quad)
          2'd0: begin
            cs_c_r[g] <= cc_c[g];
            cs_s_r[g] <= ss_c[g];
          end
          2'd1: begin
            cs_c_r[g] <= -ss_c[g];
            cs_s_r[g] <= cc_c[g];
          end
          2'd2: begin
            cs_c_r[g] <= -cc_c[g];
            cs_s_r[g] <= -ss_c[g];
          end
          default: begin
            cs_c_r[g] <= ss_c[g];
            cs_s_r[g] <= -cc_c[g];
          end
        endcase
      end
    end
  end

  // coefficient products
  logic signed [63:0] pb1c_r, pb2c_r, pb1s_r, pb2s_r;
  logic signed [63:0] pa1c_r, pa2c_r, pa1s_r, pa2s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pb1c_r <= 64'(num_c1_r) * 64'(cs_c_r[0]);
      pb2c_r <= 64'(num_c2_r) * 64'(cs_c_r[1]);
      pb1s_r <= 64'(num_c1_r) * 64'(cs_s_r[0]);
      pb2s_r <= 64'(num_c2_r) * 64'(cs_s_r[1]);
      pa1c_r <= 64'(den_c1_r) * 64'(cs_c_r[0]);
      pa2c_r <= 64'(den_c2_r) * 64'(cs_c_r[1]);
      pa1s_r <= 64'(den_c1_r) * 64'(cs_s_r[0]);
      pa2s_r <= 64'(den_c2_r) * 64'(cs_s_r[1]);
    end
  end

  // sums rounded back to coefficient scale
  logic signed [65:0] half_c, b0s_c, a0s_c, nr_s, ni_s, dr_s, di_s;
  logic signed [33:0] nr_r, ni_r, dr_r, di_r;

  always_comb begin
    half_c = 66'sd536870912;
    b0s_c  = {{4{num_c0_r[31]}}, num_c0_r, 30'b0};
    a0s_c  = {{4{den_c0_r[31]}}, den_c0_r, 30'b0};
    nr_s = b0s_c + {{2{pb1c_r[63]}}, pb1c_r} + {{2{pb2c_r[63]}}, pb2c_r} + half_c;
    ni_s = half_c - {{2{pb1s_r[63]}}, pb1s_r} - {{2{pb2s_r[63]}}, pb2s_r};
    dr_s = a0s_c + {{2{pa1c_r[63]}}, pa1c_r} + {{2{pa2c_r[63]}}, pa2c_r} + half_c;
    di_s = half_c - {{2{pa1s_r[63]}}, pa1s_r} - {{2{pa2s_r[63]}}, pa2s_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr_r <= 34'(nr_s >>> 30);
      ni_r <= 34'(ni_s >>> 30);
      dr_r <= 34'(dr_s >>> 30);
      di_r <= 34'(di_s >>> 30);
    end
  end

  // complex products as split magnitude products
  // order: nr*dr, ni*di, ni*dr, nr*di, dr*dr, di*di
  pp_t         pp_r [6];
  logic        sg_r [6];
  logic        dz_pp_r, dz_ps_r, dz_cb_r;
  logic [32:0] mnr_c, mni_c, mdr_c, mdi_c;

  assign mnr_c = mag34(nr_r);
  assign mni_c = mag34(ni_r);
  assign mdr_c = mag34(dr_r);
  assign mdi_c = mag34(di_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= pp_calc(mnr_c, mdr_c);
      pp_r[1] <= pp_calc(mni_c, mdi_c);
      pp_r[2] <= pp_calc(mni_c, mdr_c);
      pp_r[3] <= pp_calc(mnr_c, mdi_c);
      pp_r[4] <= pp_calc(mdr_c, mdr_c);
      pp_r[5] <= pp_calc(mdi_c, mdi_c);
      sg_r[0] <= nr_r[33] ^ dr_r[33];
      sg_r[1] <= ni_r[33] ^ di_r[33];
      sg_r[2] <= ni_r[33] ^ dr_r[33];
      sg_r[3] <= nr_r[33] ^ di_r[33];
      sg_r[4] <= 1'b0;
      sg_r[5] <= 1'b0;
      dz_pp_r <= (dr_r == '0) && (di_r == '0);
    end
  end

  logic [65:0] ps_r [6];
  logic        sg2_r [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        ps_r[k]  <= (66'(pp_r[k].hh) << 32) + (66'(pp_r[k].hl) << 16) +
                    (66'(pp_r[k].lh) << 16) + 66'(pp_r[k].ll);
        sg2_r[k] <= sg_r[k];
      end
      dz_ps_r <= dz_pp_r;
    end
  end

  // combine into numerators and the squared magnitude
  logic signed [67:0] sp_c [4];
  logic signed [67:0] num_re_r, num_im_r;
  logic [66:0]        den_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sp_c[k] = sg2_r[k] ? -68'(ps_r[k]) : 68'(ps_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_re_r <= sp_c[0] + sp_c[1];
      num_im_r <= sp_c[2] - sp_c[3];
      den_r    <= 67'(ps_r[4]) + 67'(ps_r[5]);
      dz_cb_r  <= dz_ps_r;
    end
  end

  // divide front: magnitude, scale and range check
  div_t        dv_r [DIV_STEPS+1][2];
  logic [66:0] dd_r [DIV_STEPS+1];
  logic        dz_d_r [DIV_STEPS+1];
  logic [66:0] nmag_c [2];
  logic [DRW-1:0] m0_c [2];
  logic [DRW-1:0] dlim_c;

  always_comb begin
    nmag_c[0] = num_re_r[67] ? 67'(-num_re_r) : 67'(num_re_r);
    nmag_c[1] = num_im_r[67] ? 67'(-num_im_r) : 67'(num_im_r);
    dlim_c    = DRW'(den_r) << 32;
    for (int g = 0; g < 2; g++) begin
      m0_c[g] = DRW'(nmag_c[g]) << 25;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0][0] <= '{m: m0_c[0], q: '0, neg: num_re_r[67], sat: m0_c[0] >= dlim_c};
      dv_r[0][1] <= '{m: m0_c[1], q: '0, neg: num_im_r[67], sat: m0_c[1] >= dlim_c};
      dd_r[0]    <= den_r;
      dz_d_r[0]  <= dz_cb_r;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int B = DIV_STEPS - 1 - i;
    logic [DRW-1:0] t_c;
    logic           ge_c [2];

    assign t_c = DRW'(dd_r[i]) << B;

    always_comb begin
      for (int g = 0; g < 2; g++) begin
        ge_c[g] = dv_r[i][g].m >= t_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int g = 0; g < 2; g++) begin
          dv_r[i+1][g].m   <= ge_c[g] ? dv_r[i][g].m - t_c : dv_r[i][g].m;
          dv_r[i+1][g].q   <= dv_r[i][g].q | (ge_c[g] ? (32'd1 << B) : 32'd0);
          dv_r[i+1][g].neg <= dv_r[i][g].neg;
          dv_r[i+1][g].sat <= dv_r[i][g].sat;
        end
        dd_r[i+1]   <= dd_r[i];
        dz_d_r[i+1] <= dz_d_r[i];
      end
    end
  end

  // final rounding, saturation and status
  logic [31:0] qr_c [2];
  logic [31:0] res_c [2];
  logic        sat_c [2];

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      qr_c[g] = 32'((33'(dv_r[DIV_STEPS][g].q) + 33'd1) >> 1);
      if (dv_r[DIV_STEPS][g].sat) begin
        sat_c[g] = 1'b1;
        res_c[g] = dv_r[DIV_STEPS][g].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if (!dv_r[DIV_STEPS][g].neg && qr_c[g][31]) begin
        sat_c[g] = 1'b1;
        res_c[g] = 32'h7FFF_FFFF;
      end else begin
        sat_c[g] = 1'b0;
        res_c[g] = dv_r[DIV_STEPS][g].neg ? -qr_c[g] : qr_c[g];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (dz_d_r[DIV_STEPS]) begin
        out_resp_real_r <= '0;
        out_resp_imag_r <= '0;
        out_status_r    <= ST_DZ;
      end else begin
        out_resp_real_r <= res_c[0];
        out_resp_imag_r <= res_c[1];
        out_status_r    <= (sat_c[0] || sat_c[1]) ? ST_SAT : ST_OK;
      end
    end
  end

  // checks
  `BFR_ASSERT(a_dz_zero, !(out_valid_r && out_status_r == ST_DZ) || (out_resp_real_r == '0 && out_resp_imag_r == '0))
  `BFR_ASSERT(a_status_code, !out_valid_r || out_status_r == ST_OK || out_status_r == ST_SAT || out_status_r == ST_DZ)
  `BFR_ASSERT_NEXT(a_front_sat, en && vld_r[NVLD-1] && !dz_d_r[DIV_STEPS] && (dv_r[DIV_STEPS][0].sat || dv_r[DIV_STEPS][1].sat), out_status_r == ST_SAT)
  `BFR_ASSERT_NEXT(a_hold, !en, $stable(vld_r) && $stable(out_resp_real_r) && $stable(out_status_r))

endmodule
